### hdl/wls_pkg.sv
// Shared types and constants for the windowed latency statistics block.
`default_nettype none
package wls_pkg;

  localparam int MODE_W    = 2;
  localparam int CAP_W     = 7;
  localparam int COUNT_W   = 7;
  localparam int TOTAL_W   = 32;
  localparam int PCT_W     = 17;
  localparam int PCT_FRAC  = 16;
  localparam int MIN_CAP   = 8;
  localparam int RESET_CAP = 64;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [PADDR_W-1:0] REG_CAPACITY = 3'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_RECORD = 2'd0,
    MODE_SWITCH = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_REPORT = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KCALC,
    ST_SCAN,
    ST_DIV,
    ST_WAIT,
    ST_FIN
  } state_e;

endpackage
`default_nettype wire

### hdl/wls_in_if.sv
// Input and result channel interfaces of the latency statistics block.
`default_nettype none
interface wls_in_if import wls_pkg::*; #(
  parameter int TIME_WIDTH   = 24,
  parameter int FRAMES_WIDTH = 16
) ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [TIME_WIDTH-1:0]   search_time;
  logic [FRAMES_WIDTH-1:0] frames_cmp;
  logic                    over_budget;
  logic [PCT_W-1:0]        percentile;

  modport source (output valid, mode, search_time, frames_cmp, over_budget,
                  percentile, input ready);
  modport sink (input valid, mode, search_time, frames_cmp, over_budget,
                percentile, output ready);
endinterface

interface wls_out_if import wls_pkg::*; #(
  parameter int TIME_WIDTH   = 24,
  parameter int FRAMES_WIDTH = 16
) ();
  logic                    valid;
  logic                    ready;
  logic [COUNT_W-1:0]      sample_count;
  logic [TOTAL_W-1:0]      search_total;
  logic [TOTAL_W-1:0]      switch_total;
  logic [TOTAL_W-1:0]      overrun_total;
  logic [TIME_WIDTH-1:0]   mean_time;
  logic [TIME_WIDTH-1:0]   percentile_time;
  logic [TIME_WIDTH-1:0]   worst_time;
  logic [FRAMES_WIDTH-1:0] mean_frames;

  modport source (output valid, sample_count, search_total, switch_total,
                  overrun_total, mean_time, percentile_time, worst_time,
                  mean_frames, input ready);
  modport sink (input valid, sample_count, search_total, switch_total,
                overrun_total, mean_time, percentile_time, worst_time,
                mean_frames, output ready);
endinterface
`default_nettype wire

### hdl/wls_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module wls_div #(
  parameter int NW = 31,
  parameter int DW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               busy_o,
  output logic [NW-1:0]      quotient_o
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo_q, quo_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    div_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW:0]      trial;
  logic             qbit;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    qbit  = (trial >= {1'b0, div_q});
    rem_d = qbit ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
    quo_d = {quo_q[NW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

### hdl/windowed_latency_statistics_top.sv
// Windowed latency statistics: sample ring, totals and report engine.
//
// Channels: in_i (sink) carries one operation per item, selected by mode:
// record a sample, count a switch, clear the window and totals, or report.
// out_o (source) carries one result item per report; other modes give none.
// An item is taken when valid and ready are both high.
// The APB port holds the window capacity at byte address 0; writing it
// clamps the value to 8..MAX_DEPTH and clears the window and all totals.
//
// Record, switch and clear are applied as they are taken; the next item may
// follow in the next cycle. A report holds off further items until its result
// is loaded: the percentile is found by a bit-by-bit radix select, one full
// pass over the single-ported sample memory per time bit, followed by the
// mean dividers. An empty window skips the sweep and the dividers and goes
// straight to the finish state.
//
// Reset empties the window, zeroes the totals and sets capacity to 64
// (or MAX_DEPTH if smaller). The result waits in an output register; while
// the receiver stalls, records and events are still taken, and a further
// report finishes its sweep then holds until the register frees.
`default_nettype none
module windowed_latency_statistics_top import wls_pkg::*; #(
  parameter int MAX_DEPTH    = 64,
  parameter int TIME_WIDTH   = 24,
  parameter int FRAMES_WIDTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  wls_in_if.sink                  in_i,
  wls_out_if.source               out_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int AW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW   = $clog2(MAX_DEPTH + 1);
  localparam int TSW  = TIME_WIDTH + CW;
  localparam int FSW  = FRAMES_WIDTH + CW;
  localparam int KPW  = PCT_W + CW;
  localparam int RCAP = (RESET_CAP > MAX_DEPTH) ? MAX_DEPTH : RESET_CAP;

  // sample memories
  logic [TIME_WIDTH-1:0]   time_mem   [MAX_DEPTH];
  logic [FRAMES_WIDTH-1:0] frames_mem [MAX_DEPTH];

  state_e state_q, state_d;

  logic [CW-1:0]      cap_q, fill_q;
  logic [AW-1:0]      wp_q;
  logic [TOTAL_W-1:0] search_q, switch_q, overrun_q;

  logic [CW-1:0]         n_q, k_q, addr_q, cnt_q;
  logic [PCT_W-1:0]      p_q;
  logic                  dv_q;
  logic [TIME_WIDTH-1:0] sel_q, hi_mask_q, prefix_q, worst_q, rd_t_q;
  logic [FRAMES_WIDTH-1:0] rd_f_q;
  logic [TSW-1:0]        tsum_q;
  logic [FSW-1:0]        fsum_q;

  logic          out_valid_q;
  logic          in_acc, cfg_wr, rd_en, pass_end, match, load_out, div_start;
  logic          tdiv_busy, fdiv_busy;
  logic [TSW-1:0] tquo;
  logic [FSW-1:0] fquo;
  logic [KPW-1:0] kprod;
  logic [CW:0]    kraw;
  logic [CW-1:0]  nm1, cap_new;
  logic [CAP_W-1:0] cap_wr;
  mode_e          mode;

  assign mode   = mode_e'(in_i.mode);
  assign in_acc = in_i.valid && in_i.ready;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_CAPACITY);
  assign pready = 1'b1;
  assign prdata = (paddr == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

  always_comb begin
    cap_wr = pwdata[CAP_W-1:0];
    if (int'(cap_wr) < MIN_CAP) begin
      cap_new = CW'(MIN_CAP);
    end else if (int'(cap_wr) > MAX_DEPTH) begin
      cap_new = CW'(MAX_DEPTH);
    end else begin
      cap_new = CW'(cap_wr);
    end
  end

  // percentile rank
  assign nm1   = n_q - 1'b1;
  assign kprod = KPW'(p_q) * KPW'(nm1);
  assign kraw  = kprod[KPW-1:PCT_FRAC];

  assign rd_en    = (state_q == ST_SCAN) && (addr_q < n_q);
  assign pass_end = (state_q == ST_SCAN) && !rd_en && !dv_q;
  assign match    = (((rd_t_q ^ prefix_q) & hi_mask_q) == '0) && ((rd_t_q & sel_q) == '0);

  always_comb begin
    state_d   = state_q;
    in_i.ready = 1'b0;
    load_out  = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_acc && mode == MODE_REPORT) begin
          state_d = (fill_q == '0) ? ST_FIN : ST_KCALC;
        end
      end
      ST_KCALC: state_d = ST_SCAN;
      ST_SCAN: begin
        if (pass_end && sel_q[0]) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (!tdiv_busy && !fdiv_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // window control and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CW'(RCAP);
      wp_q      <= '0;
      fill_q    <= '0;
      search_q  <= '0;
      switch_q  <= '0;
      overrun_q <= '0;
    end else if (cfg_wr) begin
      cap_q     <= cap_new;
      wp_q      <= '0;
      fill_q    <= '0;
      search_q  <= '0;
      switch_q  <= '0;
      overrun_q <= '0;
    end else if (in_acc) begin
      unique case (mode)
        MODE_RECORD: begin
          wp_q     <= (CW'(wp_q) + 1'b1 == cap_q) ? '0 : wp_q + 1'b1;
          if (fill_q < cap_q) fill_q <= fill_q + 1'b1;
          search_q <= search_q + 1'b1;
          if (in_i.over_budget) overrun_q <= overrun_q + 1'b1;
        end
        MODE_SWITCH: switch_q <= switch_q + 1'b1;
        MODE_CLEAR: begin
          wp_q      <= '0;
          fill_q    <= '0;
          search_q  <= '0;
          switch_q  <= '0;
          overrun_q <= '0;
        end
        MODE_REPORT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && mode == MODE_RECORD) begin
      time_mem[wp_q]   <= in_i.search_time;
      frames_mem[wp_q] <= in_i.frames_cmp;
    end
    if (rd_en) begin
      rd_t_q <= time_mem[addr_q[AW-1:0]];
      rd_f_q <= frames_mem[addr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q   <= 1'b0;
      addr_q <= '0;
    end else begin
      dv_q <= rd_en;
      if (rd_en) begin
        addr_q <= addr_q + 1'b1;
      end else if (pass_end || state_q == ST_IDLE) begin
        addr_q <= '0;
      end
    end
  end

  // radix select and sums
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      n_q       <= fill_q;
      p_q       <= in_i.percentile;
      sel_q     <= {1'b1, {(TIME_WIDTH-1){1'b0}}};
      hi_mask_q <= '0;
      prefix_q  <= '0;
      cnt_q     <= '0;
      tsum_q    <= '0;
      fsum_q    <= '0;
      worst_q   <= '0;
    end
    if (state_q == ST_KCALC) begin
      k_q <= (kraw > {1'b0, nm1}) ? nm1 : kraw[CW-1:0];
    end
    if (dv_q) begin
      if (match) cnt_q <= cnt_q + 1'b1;
      if (sel_q[TIME_WIDTH-1]) begin
        tsum_q <= tsum_q + TSW'(rd_t_q);
        fsum_q <= fsum_q + FSW'(rd_f_q);
        if (rd_t_q > worst_q) worst_q <= rd_t_q;
      end
    end
    if (pass_end) begin
      if (k_q >= cnt_q) begin
        prefix_q <= prefix_q | sel_q;
        k_q      <= k_q - cnt_q;
      end
      hi_mask_q <= hi_mask_q | sel_q;
      sel_q     <= sel_q >> 1;
      cnt_q     <= '0;
    end
  end

  wls_div #(.NW(TSW), .DW(CW)) u_tdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tsum_q),
    .divisor_i  (n_q),
    .busy_o     (tdiv_busy),
    .quotient_o (tquo)
  );

  wls_div #(.NW(FSW), .DW(CW)) u_fdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (fsum_q),
    .divisor_i  (n_q),
    .busy_o     (fdiv_busy),
    .quotient_o (fquo)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_o.sample_count    <= COUNT_W'(n_q);
      out_o.search_total    <= search_q;
      out_o.switch_total    <= switch_q;
      out_o.overrun_total   <= overrun_q;
      out_o.mean_time       <= (n_q == '0) ? '0 : tquo[TIME_WIDTH-1:0];
      out_o.percentile_time <= (n_q == '0) ? '0 : prefix_q;
      out_o.worst_time      <= worst_q;
      out_o.mean_frames     <= (n_q == '0) ? '0 : fquo[FRAMES_WIDTH-1:0];
    end
  end

  assign out_o.valid = out_valid_q;

`ifndef SYNTHESIS
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_q) else $error("fill exceeds capacity");
  a_wp_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(wp_q) < cap_q) else $error("write pointer beyond capacity");
  a_scan_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (n_q != '0 && k_q < n_q)) else $error("bad rank in scan");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> (!tdiv_busy && !fdiv_busy)) else $error("divider busy at finish");
`endif

endmodule
`default_nettype wire

### tb/windowed_latency_statistics_top_tb.sv
// Testbench for the windowed latency statistics block: stimulus, prediction and checks.
`timescale 1ns / 100ps
module windowed_latency_statistics_top_tb;
  import wls_pkg::*;

  localparam int TW = 24;
  localparam int FW = 16;
  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    mode_e            mode;
    logic [TW-1:0]    search_time;
    logic [FW-1:0]    frames_cmp;
    logic             over_budget;
    logic [PCT_W-1:0] percentile;
  } op_t;

  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic [TOTAL_W-1:0] search_total;
    logic [TOTAL_W-1:0] switch_total;
    logic [TOTAL_W-1:0] overrun_total;
    logic [TW-1:0]      mean_time;
    logic [TW-1:0]      percentile_time;
    logic [TW-1:0]      worst_time;
    logic [FW-1:0]      mean_frames;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  wls_in_if  #(.TIME_WIDTH(TW), .FRAMES_WIDTH(FW)) in_ch ();
  wls_out_if #(.TIME_WIDTH(TW), .FRAMES_WIDTH(FW)) out_ch ();

  windowed_latency_statistics_top #(.MAX_DEPTH(DEPTH), .TIME_WIDTH(TW), .FRAMES_WIDTH(FW)) dut (
    .clk_i, .rst_ni, .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [TW-1:0] ring_time [DEPTH];
  logic [FW-1:0] ring_frames [DEPTH];
  int unsigned ring_wp, ring_fill, ring_cap;
  logic [31:0] cnt_search, cnt_switch, cnt_overrun;

  op_t    pending_ops[$];
  stats_t expected_stats[$];
  int     n_fail = 0;
  int     idle_cycles = 0;
  int     hold_off = 0;
  int     send_gap = 0;
  bit     hold_req = 1'b0;
  bit     long_hold = 1'b0;

  task automatic clear_stats();
    ring_wp = 0; ring_fill = 0;
    cnt_search = '0; cnt_switch = '0; cnt_overrun = '0;
  endtask

  function automatic logic [TW-1:0] kth_time(int unsigned n, int unsigned k);
    logic [TW-1:0] vals[$];
    for (int i = 0; i < n; i++) vals.push_back(ring_time[i]);
    vals.sort();
    return vals[k];
  endfunction

  task automatic apply_op(op_t op);
    stats_t r;
    logic [63:0] tsum, fsum, k;
    if (op.mode == MODE_RECORD) begin
      ring_time[ring_wp] = op.search_time;
      ring_frames[ring_wp] = op.frames_cmp;
      ring_wp = (ring_wp + 1) % ring_cap;
      if (ring_fill < ring_cap) ring_fill++;
      cnt_search++;
      if (op.over_budget) cnt_overrun++;
    end else if (op.mode == MODE_SWITCH) begin
      cnt_switch++;
    end else if (op.mode == MODE_CLEAR) begin
      clear_stats();
    end else begin
      r = '0;
      r.sample_count = COUNT_W'(ring_fill);
      r.search_total = cnt_search;
      r.switch_total = cnt_switch;
      r.overrun_total = cnt_overrun;
      if (ring_fill > 0) begin
        tsum = 0; fsum = 0;
        for (int i = 0; i < ring_fill; i++) begin
          tsum += ring_time[i];
          fsum += ring_frames[i];
          if (ring_time[i] > r.worst_time) r.worst_time = ring_time[i];
        end
        r.mean_time = TW'(tsum / ring_fill);
        r.mean_frames = FW'(fsum / ring_fill);
        k = (64'(op.percentile) * 64'(ring_fill - 1)) >> PCT_FRAC;
        if (k > 64'(ring_fill - 1)) k = 64'(ring_fill - 1);
        r.percentile_time = kth_time(ring_fill, 32'(k));
      end
      expected_stats.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    n_fail++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= MODE_RECORD;
      in_ch.search_time <= '0;
      in_ch.frames_cmp <= '0;
      in_ch.over_budget <= 1'b0;
      in_ch.percentile <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_op(op_t'({in_ch.mode, in_ch.search_time, in_ch.frames_cmp,
                        in_ch.over_budget, in_ch.percentile}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() > 0 && (send_gap == 0 || hold_req)) begin
          op_t op;
          op = pending_ops.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode <= op.mode;
          in_ch.search_time <= op.search_time;
          in_ch.frames_cmp <= op.frames_cmp;
          in_ch.over_budget <= op.over_budget;
          in_ch.percentile <= op.percentile;
          // mostly short gaps, now and then a long one
          if ($urandom_range(0, 39) == 0) send_gap = $urandom_range(20, 150);
          else send_gap = $urandom_range(0, 2);
        end else begin
          if (send_gap > 0) send_gap--;
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          stats_t e;
          e = expected_stats.pop_front();
          if (out_ch.sample_count !== e.sample_count)
            report_mismatch("sample_count", out_ch.sample_count, e.sample_count);
          if (out_ch.search_total !== e.search_total)
            report_mismatch("search_total", out_ch.search_total, e.search_total);
          if (out_ch.switch_total !== e.switch_total)
            report_mismatch("switch_total", out_ch.switch_total, e.switch_total);
          if (out_ch.overrun_total !== e.overrun_total)
            report_mismatch("overrun_total", out_ch.overrun_total, e.overrun_total);
          if (out_ch.mean_time !== e.mean_time)
            report_mismatch("mean_time", out_ch.mean_time, e.mean_time);
          if (out_ch.percentile_time !== e.percentile_time)
            report_mismatch("percentile_time", out_ch.percentile_time, e.percentile_time);
          if (out_ch.worst_time !== e.worst_time)
            report_mismatch("worst_time", out_ch.worst_time, e.worst_time);
          if (out_ch.mean_frames !== e.mean_frames)
            report_mismatch("mean_frames", out_ch.mean_frames, e.mean_frames);
        end
      end
      if (hold_req && !long_hold) begin
        hold_off = 3000;
        long_hold = 1'b1;
      end
      if (hold_off > 0) begin
        hold_off--;
        if (hold_off == 0 && long_hold) begin
          hold_req = 1'b0;
          long_hold = 1'b0;
        end
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        hold_off = $urandom_range(20, 200);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_capacity(logic [CAP_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_CAPACITY; pwdata <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    ring_cap = value < MIN_CAP ? MIN_CAP : (value > DEPTH ? DEPTH : value);
    clear_stats();
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_ch.valid || expected_stats.size() > 0)
      @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  function automatic op_t make_op(mode_e m, logic [TW-1:0] t, logic [FW-1:0] f,
                                  logic ob, logic [PCT_W-1:0] p);
    return op_t'({m, t, f, ob, p});
  endfunction

  function automatic op_t random_op(int unsigned report_odds);
    op_t op;
    int unsigned r;
    r = $urandom_range(0, 99);
    op.search_time = ($urandom_range(0, 3) == 0) ? TW'($urandom) : TW'($urandom_range(0, 4095));
    op.frames_cmp = FW'($urandom);
    op.over_budget = 1'($urandom_range(0, 1));
    op.percentile = PCT_W'($urandom_range(0, 65536));
    if ($urandom_range(0, 7) == 0) op.percentile = PCT_W'($urandom);
    if (r < report_odds) op.mode = MODE_REPORT;
    else if (r < 80) op.mode = MODE_RECORD;
    else if (r < 97) op.mode = MODE_SWITCH;
    else op.mode = MODE_CLEAR;
    return op;
  endfunction

  initial begin
    int unsigned caps[5] = '{7'd0, 7'd8, 7'd13, 7'd64, 7'd127};
    ring_cap = RESET_CAP;
    clear_stats();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty report, extremes, percentile above one, clear
    pending_ops.push_back(make_op(MODE_REPORT, 0, 0, 0, 0));
    pending_ops.push_back(make_op(MODE_RECORD, '1, '1, 1, 0));
    pending_ops.push_back(make_op(MODE_RECORD, 0, 0, 0, 0));
    pending_ops.push_back(make_op(MODE_RECORD, 24'h123456, 16'h8001, 1, 0));
    pending_ops.push_back(make_op(MODE_SWITCH, 0, 0, 0, 0));
    pending_ops.push_back(make_op(MODE_REPORT, 0, 0, 0, 17'h10000));
    pending_ops.push_back(make_op(MODE_REPORT, 0, 0, 0, '1));
    pending_ops.push_back(make_op(MODE_REPORT, 0, 0, 0, 17'h08000));
    pending_ops.push_back(make_op(MODE_CLEAR, 0, 0, 0, 0));
    pending_ops.push_back(make_op(MODE_REPORT, 0, 0, 0, 17'h0ffff));
    wait_drained();

    // random phases at several capacities, wrapping the ring
    foreach (caps[c]) begin
      write_capacity(CAP_W'(caps[c]));
      for (int i = 0; i < 200; i++) pending_ops.push_back(random_op(8));
      if (c == 1) begin
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
          pending_ops.push_back(make_op(MODE_REPORT, 0, 0, 0,
                                        PCT_W'($urandom_range(0, 65536))));
      end
      wait_drained();
    end

    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/wls_pkg.sv
hdl/wls_in_if.sv
hdl/wls_div.sv
hdl/windowed_latency_statistics_top.sv
tb/windowed_latency_statistics_top_tb.sv
